/* hw/rtl/ulal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulal_pkg
// Shared types, widths and constants of the lookahead linearizer core.
// ----------------------------------------------------------------------------
package ulal_pkg;

  localparam int CORDIC_STEPS_DEF = 14;
  localparam int ATAN_LEN         = 24;

  // CORDIC datapath widths (Q2.30 vectors, 2^31 = pi angles, with headroom)
  localparam int VEC_W = 34;
  localparam int ANG_W = 34;
  // reference speeds after optional negation
  localparam int REF_W = 17;
  localparam int PROD_W = VEC_W + REF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int U_W    = 26;
  localparam int CMD_W  = 42;
  localparam int OUT_SUM_W = 44;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [VEC_W-1:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] HALF_PI_ANG = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] PI_ANG      = 34'sd2147483648;

  localparam logic signed [SUM_W-1:0]     ROUND_U   = SUM_W'(1) <<< 21;
  localparam logic signed [OUT_SUM_W-1:0] ROUND_CMD = OUT_SUM_W'(1) <<< 19;
  localparam logic signed [OUT_SUM_W-1:0] SAT_MAX   = 44'sd32767;
  localparam logic signed [OUT_SUM_W-1:0] SAT_MIN   = -44'sd32768;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21353441,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_AMP     = 3'd0,
    REG_Y_AMP     = 3'd1,
    REG_X_STEP    = 3'd2,
    REG_Y_STEP    = 3'd3,
    REG_INV_OFF_X = 3'd4,
    REG_OFF_RATIO = 3'd5
  } ulal_reg_t;

  // sideband that rides along the CORDIC pipeline
  typedef struct packed {
    logic [31:0]              sample_time;
    logic signed [REF_W-1:0]  x_ref;
    logic signed [REF_W-1:0]  y_ref;
  } ulal_tag_t;

endpackage

/* hw/rtl/ulal_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulal_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ulal_cordic
  import ulal_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_z,
  input  ulal_tag_t               in_tag,
  output logic                    out_valid,
  output logic signed [VEC_W-1:0] out_x,
  output logic signed [VEC_W-1:0] out_y,
  output ulal_tag_t               out_tag
);

  logic                    vld_r [1:STEPS];
  logic signed [VEC_W-1:0] x_r   [1:STEPS];
  logic signed [VEC_W-1:0] y_r   [1:STEPS];
  logic signed [ANG_W-1:0] z_r   [1:STEPS];
  ulal_tag_t               tag_r [1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic                    vld_in;
    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [ANG_W-1:0] z_in;
    ulal_tag_t               tag_in;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    if (k == 0) begin : g_entry
      // entry point: gain-compensated unit vector on the x axis
      assign vld_in = in_valid;
      assign x_in   = CORDIC_X0;
      assign y_in   = '0;
      assign z_in   = in_z;
      assign tag_in = in_tag;
    end else begin : g_chain
      assign vld_in = vld_r[k];
      assign x_in   = x_r[k];
      assign y_in   = y_r[k];
      assign z_in   = z_r[k];
      assign tag_in = tag_r[k];
    end

    assign dx = x_in >>> k;
    assign dy = y_in >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1] <= tag_in;
        // rotate toward zero residual angle
        if (!z_in[ANG_W-1]) begin
          x_r[k+1] <= x_in - dy;
          y_r[k+1] <= y_in + dx;
          z_r[k+1] <= z_in - ATAN_TAB[k];
        end else begin
          x_r[k+1] <= x_in + dy;
          y_r[k+1] <= y_in - dx;
          z_r[k+1] <= z_in + ATAN_TAB[k];
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_x     = x_r[STEPS];
  assign out_y     = y_r[STEPS];
  assign out_tag   = tag_r[STEPS];

endmodule

/* hw/rtl/unicycle_lookahead_linearizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicycle_lookahead_linearizer_core
// Lookahead-point feedback linearization of a unicycle with step references.
// ----------------------------------------------------------------------------
// Input stream (in_*): one transaction per pose sample, carrying the heading
// angle and the sample time. Output stream (out_*): one transaction per
// sample with the echoed time, forward speed, turn rate and a clip flag,
// in input order.
// The configuration port writes the step amplitudes, step times and the
// offset coefficients; write it only while no sample is in flight.
// The pipeline is an input register, one register per CORDIC micro-rotation
// (CORDIC_STEPS of them, capped at 24, default 14), two multiply stages, a
// rounding stage and the output register. Throughput is one sample per cycle
// while results are taken; the CORDIC chain sets the depth, not the rate.
// When the receiver stalls the whole pipeline holds and in_tready drops in
// the same cycle; nothing is lost or repeated. Reset (rst_n low at a clock
// edge) empties the pipeline and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module unicycle_lookahead_linearizer_core
  import ulal_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: heading_angle[15:0], sample_time[47:16]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,
  // out_tdata: time_echo[31:0], forward_speed[47:32], turn_rate[63:48],
  //            saturated[64], zero[71:65]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CORDIC_LEN = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] x_amp_r, y_amp_r, inv_off_r, ratio_r;
  logic [31:0]        x_step_r, y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_amp_r   <= '0;
      y_amp_r   <= '0;
      x_step_r  <= '0;
      y_step_r  <= '0;
      inv_off_r <= 16'sd4096;
      ratio_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_AMP:     x_amp_r   <= cfg_wdata[15:0];
        REG_Y_AMP:     y_amp_r   <= cfg_wdata[15:0];
        REG_X_STEP:    x_step_r  <= cfg_wdata;
        REG_Y_STEP:    y_step_r  <= cfg_wdata;
        REG_INV_OFF_X: inv_off_r <= cfg_wdata[15:0];
        REG_OFF_RATIO: ratio_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: everything advances unless a result waits untaken
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // Stage 0: fold the heading to +-pi/2, form the step references
  // --------------------------------------------------------------------------
  logic signed [15:0]      heading;
  logic [31:0]             sample_time;
  logic signed [ANG_W-1:0] z_ext, z_fold;
  logic                    fold;
  logic signed [REF_W-1:0] x_ref, y_ref;
  ulal_tag_t               tag_nxt;

  assign heading     = in_tdata[15:0];
  assign sample_time = in_tdata[47:16];
  assign z_ext       = {{(ANG_W-32){heading[15]}}, heading, 16'h0000};

  always_comb begin
    fold   = 1'b0;
    z_fold = z_ext;
    priority if (z_ext > HALF_PI_ANG) begin
      z_fold = z_ext - PI_ANG;
      fold   = 1'b1;
    end else if (z_ext < -HALF_PI_ANG) begin
      z_fold = z_ext + PI_ANG;
      fold   = 1'b1;
    end else begin
      z_fold = z_ext;
    end
  end

  assign x_ref = (sample_time >= x_step_r) ? REF_W'(x_amp_r) : '0;
  assign y_ref = (sample_time >= y_step_r) ? REF_W'(y_amp_r) : '0;

  // a folded angle negates sine and cosine; push the sign onto the references
  always_comb begin
    tag_nxt.sample_time = sample_time;
    tag_nxt.x_ref       = fold ? -x_ref : x_ref;
    tag_nxt.y_ref       = fold ? -y_ref : y_ref;
  end

  logic                    s0_valid_r;
  logic signed [ANG_W-1:0] s0_z_r;
  ulal_tag_t               s0_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_z_r   <= z_fold;
      s0_tag_r <= tag_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC chain
  // --------------------------------------------------------------------------
  logic                    cd_valid;
  logic signed [VEC_W-1:0] cd_cos, cd_sin;
  ulal_tag_t               cd_tag;

  ulal_cordic #(
    .STEPS (CORDIC_LEN)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_valid_r),
    .in_z      (s0_z_r),
    .in_tag    (s0_tag_r),
    .out_valid (cd_valid),
    .out_x     (cd_cos),
    .out_y     (cd_sin),
    .out_tag   (cd_tag)
  );

  // --------------------------------------------------------------------------
  // Stage M1: four rotation products
  // --------------------------------------------------------------------------
  logic                     m1_valid_r;
  logic [31:0]              m1_time_r;
  logic signed [PROD_W-1:0] p_cx_r, p_sy_r, p_cy_r, p_sx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_time_r <= cd_tag.sample_time;
      p_cx_r    <= PROD_W'(cd_cos) * PROD_W'(cd_tag.x_ref);
      p_sy_r    <= PROD_W'(cd_sin) * PROD_W'(cd_tag.y_ref);
      p_cy_r    <= PROD_W'(cd_cos) * PROD_W'(cd_tag.y_ref);
      p_sx_r    <= PROD_W'(cd_sin) * PROD_W'(cd_tag.x_ref);
    end
  end

  // --------------------------------------------------------------------------
  // Stage M2: combine and round to Q8.16
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] u1_sum, u2_sum, u1_shift, u2_shift;

  assign u1_sum   = SUM_W'(p_cx_r) + SUM_W'(p_sy_r) + ROUND_U;
  assign u2_sum   = SUM_W'(p_cy_r) - SUM_W'(p_sx_r) + ROUND_U;
  assign u1_shift = u1_sum >>> 22;
  assign u2_shift = u2_sum >>> 22;

  logic                  m2_valid_r;
  logic [31:0]           m2_time_r;
  logic signed [U_W-1:0] u1_r, u2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else if (en) begin
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_time_r <= m1_time_r;
      u1_r      <= u1_shift[U_W-1:0];
      u2_r      <= u2_shift[U_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage M3: offset coefficient products
  // --------------------------------------------------------------------------
  logic                    m3_valid_r;
  logic [31:0]             m3_time_r;
  logic signed [U_W-1:0]   m3_u1_r;
  logic signed [CMD_W-1:0] p_ratio_r, p_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_valid_r <= 1'b0;
    end else if (en) begin
      m3_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_time_r <= m2_time_r;
      m3_u1_r   <= u1_r;
      p_ratio_r <= CMD_W'(u2_r) * CMD_W'(ratio_r);
      p_inv_r   <= CMD_W'(u2_r) * CMD_W'(inv_off_r);
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: round to Q8.8 and clamp
  // --------------------------------------------------------------------------
  logic signed [OUT_SUM_W-1:0] v_sum, w_sum, v_shift, w_shift;
  logic signed [15:0]          v_sat, w_sat;
  logic                        v_clip, w_clip;

  assign v_sum   = (OUT_SUM_W'(m3_u1_r) <<< 12) + OUT_SUM_W'(p_ratio_r) + ROUND_CMD;
  assign w_sum   = OUT_SUM_W'(p_inv_r) + ROUND_CMD;
  assign v_shift = v_sum >>> 20;
  assign w_shift = w_sum >>> 20;

  always_comb begin
    v_clip = 1'b1;
    w_clip = 1'b1;
    priority if (v_shift > SAT_MAX) begin
      v_sat = 16'sh7FFF;
    end else if (v_shift < SAT_MIN) begin
      v_sat = -16'sh8000;
    end else begin
      v_sat  = v_shift[15:0];
      v_clip = 1'b0;
    end
    priority if (w_shift > SAT_MAX) begin
      w_sat = 16'sh7FFF;
    end else if (w_shift < SAT_MIN) begin
      w_sat = -16'sh8000;
    end else begin
      w_sat  = w_shift[15:0];
      w_clip = 1'b0;
    end
  end

  logic [31:0] out_time_r;
  logic [15:0] out_fwd_r, out_turn_r;
  logic        out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_time_r <= m3_time_r;
      out_fwd_r  <= v_sat;
      out_turn_r <= w_sat;
      out_sat_r  <= v_clip || w_clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_sat_r, out_turn_r, out_fwd_r, out_time_r};

endmodule

/* hw/rtl/ulal_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulal_checker
// Port-level checks of the lookahead linearizer core, bound to the top level.
// ----------------------------------------------------------------------------
module ulal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  // with the output register empty the pipeline always moves
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // the clip flag only comes with a clamped value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |->
      out_tdata[47:32] == 16'h7FFF || out_tdata[47:32] == 16'h8000 ||
      out_tdata[63:48] == 16'h7FFF || out_tdata[63:48] == 16'h8000)
    else $error("saturated flag without clamped output");

  // the pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result present right after reset");

endmodule

bind unicycle_lookahead_linearizer_core ulal_checker u_ulal_checker (.*);
